// ===== design/disjoint_set_union_find_core_defines.svh =====
// Assertion macros shared by the disjoint-set engine.
`ifndef DISJOINT_SET_UNION_FIND_CORE_DEFINES_SVH
`define DISJOINT_SET_UNION_FIND_CORE_DEFINES_SVH

`ifndef SYNTHESIS

// Consequent must hold in the same cycle as the antecedent.
`define DSU_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("disjoint set engine: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("disjoint set engine: assertion failed");

`else

`define DSU_ASSERT_SAME(label, clk, rst, ante, cons)
`define DSU_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ===== design/dsu_pkg.sv =====
package dsu_pkg;

   localparam int DSU_ELEMENTS = 1024;
   localparam int ELEM_W       = 10;
   localparam int KIND_W       = 2;
   localparam int ROOT_W       = 10;
   // wide enough to hold any legal element count for compares
   localparam int CMP_W        = 17;

   localparam logic [KIND_W-1:0] KIND_FIND  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_UNITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE  = 2'd3;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WALK_RD,
      ST_WALK_CHK,
      ST_COMP_RD,
      ST_COMP_CHK,
      ST_LINK,
      ST_DONE
   } dsu_state_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
   } dsu_mem_ctl_type;

endpackage

// ===== design/dsu_ram.sv =====
module dsu_ram #(
   parameter int ELEMENTS = dsu_pkg::DSU_ELEMENTS
) (
   input  logic                         clock,
   input  dsu_pkg::dsu_mem_ctl_type     mem_ctl,
   input  logic [$clog2(ELEMENTS)-1:0]  raddr,
   input  logic [$clog2(ELEMENTS)-1:0]  waddr,
   input  logic [$clog2(ELEMENTS)-1:0]  wdata,
   output logic [$clog2(ELEMENTS)-1:0]  rdata
);

   localparam int IDX_W = $clog2(ELEMENTS);

   logic [IDX_W-1:0] parent_ff [ELEMENTS];
   logic [IDX_W-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         parent_ff[waddr] <= wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_ctl.rd_en) begin
         rdata_ff <= parent_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== design/dsu_seq.sv =====
`include "disjoint_set_union_find_core_defines.svh"

module dsu_seq #(
   parameter int ELEMENTS = dsu_pkg::DSU_ELEMENTS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [dsu_pkg::KIND_W-1:0]         kind,
   input  logic [$clog2(ELEMENTS)-1:0]        elem_a,
   input  logic [$clog2(ELEMENTS)-1:0]        elem_b,
   input  logic                               out_free,
   output logic                               ready,
   output logic                               out_load,
   output logic [$clog2(ELEMENTS)-1:0]        res_root,
   output logic                               res_merged,
   output dsu_pkg::dsu_mem_ctl_type           mem_ctl,
   output logic [$clog2(ELEMENTS)-1:0]        raddr,
   output logic [$clog2(ELEMENTS)-1:0]        waddr,
   output logic [$clog2(ELEMENTS)-1:0]        wdata,
   input  logic [$clog2(ELEMENTS)-1:0]        rdata
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ELEMENTS - 1);

   dsu_pkg::dsu_state_type state_ff, state_in;

   logic [dsu_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [IDX_W-1:0] elem_b_ff, elem_b_in;
   logic             second_ff, second_in;
   logic [IDX_W-1:0] cur_ff, cur_in;
   logic [IDX_W-1:0] start_ff, start_in;
   logic [IDX_W-1:0] root_ff, root_in;
   logic [IDX_W-1:0] ra_ff, ra_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic             report_ff, report_in;
   logic [IDX_W-1:0] res_root_ff, res_root_in;
   logic             res_merged_ff, res_merged_in;

   logic at_root;
   logic at_target;

   // compare units: parent link against current pointer and against found root
   assign at_root   = (rdata == cur_ff);
   assign at_target = (rdata == root_ff);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dsu_pkg::ST_CLEAR: begin
            if (cnt_ff == LAST_IDX) begin
               state_in = report_ff ? dsu_pkg::ST_DONE : dsu_pkg::ST_IDLE;
            end
         end
         dsu_pkg::ST_IDLE: begin
            if (start) begin
               unique case (kind) inside
                  dsu_pkg::KIND_FIND, dsu_pkg::KIND_UNITE: state_in = dsu_pkg::ST_WALK_RD;
                  dsu_pkg::KIND_CLEAR:                     state_in = dsu_pkg::ST_CLEAR;
                  default:                                 state_in = dsu_pkg::ST_DONE;
               endcase
            end
         end
         dsu_pkg::ST_WALK_RD: state_in = dsu_pkg::ST_WALK_CHK;
         dsu_pkg::ST_WALK_CHK: begin
            if (at_root) begin
               state_in = dsu_pkg::ST_COMP_RD;
            end
         end
         dsu_pkg::ST_COMP_RD: state_in = dsu_pkg::ST_COMP_CHK;
         dsu_pkg::ST_COMP_CHK: begin
            if (at_target) begin
               if (kind_ff != dsu_pkg::KIND_UNITE) begin
                  state_in = dsu_pkg::ST_DONE;
               end else if (!second_ff) begin
                  state_in = dsu_pkg::ST_WALK_RD;
               end else if (ra_ff != root_ff) begin
                  state_in = dsu_pkg::ST_LINK;
               end else begin
                  state_in = dsu_pkg::ST_DONE;
               end
            end
         end
         dsu_pkg::ST_LINK: state_in = dsu_pkg::ST_DONE;
         dsu_pkg::ST_DONE: begin
            if (out_free) begin
               state_in = dsu_pkg::ST_IDLE;
            end
         end
         default: state_in = dsu_pkg::ST_IDLE;
      endcase
   end

   // outputs: memory port and handshake
   always_comb begin
      mem_ctl  = '0;
      raddr    = cur_ff;
      waddr    = cnt_ff;
      wdata    = cnt_ff;
      ready    = 1'b0;
      out_load = 1'b0;
      unique case (state_ff) inside
         dsu_pkg::ST_CLEAR: begin
            mem_ctl.wr_en = 1'b1;
         end
         dsu_pkg::ST_IDLE: begin
            ready = 1'b1;
         end
         dsu_pkg::ST_WALK_RD, dsu_pkg::ST_COMP_RD: begin
            mem_ctl.rd_en = 1'b1;
         end
         dsu_pkg::ST_WALK_CHK: begin
            if (!at_root) begin
               mem_ctl.rd_en = 1'b1;
               raddr         = rdata;
            end
         end
         dsu_pkg::ST_COMP_CHK: begin
            if (!at_target) begin
               mem_ctl.rd_en = 1'b1;
               mem_ctl.wr_en = 1'b1;
               raddr         = rdata;
               waddr         = cur_ff;
               wdata         = root_ff;
            end
         end
         dsu_pkg::ST_LINK: begin
            mem_ctl.wr_en = 1'b1;
            waddr         = ra_ff;
            wdata         = root_ff;
         end
         dsu_pkg::ST_DONE: begin
            out_load = out_free;
         end
         default: begin
            mem_ctl = '0;
         end
      endcase
   end

   // datapath
   always_comb begin
      kind_in       = kind_ff;
      elem_b_in     = elem_b_ff;
      second_in     = second_ff;
      cur_in        = cur_ff;
      start_in      = start_ff;
      root_in       = root_ff;
      ra_in         = ra_ff;
      cnt_in        = cnt_ff;
      report_in     = report_ff;
      res_root_in   = res_root_ff;
      res_merged_in = res_merged_ff;
      case (state_ff)
         dsu_pkg::ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
         end
         dsu_pkg::ST_IDLE: begin
            if (start) begin
               kind_in       = kind;
               elem_b_in     = elem_b;
               second_in     = 1'b0;
               cur_in        = elem_a;
               start_in      = elem_a;
               cnt_in        = '0;
               report_in     = 1'b1;
               res_root_in   = '0;
               res_merged_in = 1'b0;
            end
         end
         dsu_pkg::ST_WALK_CHK: begin
            if (at_root) begin
               root_in = cur_ff;
               cur_in  = start_ff;
            end else begin
               cur_in = rdata;
            end
         end
         dsu_pkg::ST_COMP_CHK: begin
            if (!at_target) begin
               cur_in = rdata;
            end else if (kind_ff == dsu_pkg::KIND_UNITE && !second_ff) begin
               ra_in     = root_ff;
               second_in = 1'b1;
               cur_in    = elem_b_ff;
               start_in  = elem_b_ff;
            end else begin
               res_root_in   = root_ff;
               res_merged_in = (kind_ff == dsu_pkg::KIND_UNITE) && (ra_ff != root_ff);
            end
         end
         default: begin
            cnt_in = cnt_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= dsu_pkg::ST_CLEAR;
         cnt_ff    <= '0;
         report_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         report_ff <= report_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      elem_b_ff     <= elem_b_in;
      second_ff     <= second_in;
      cur_ff        <= cur_in;
      start_ff      <= start_in;
      root_ff       <= root_in;
      ra_ff         <= ra_in;
      res_root_ff   <= res_root_in;
      res_merged_ff <= res_merged_in;
   end

   assign res_root   = res_root_ff;
   assign res_merged = res_merged_ff;

   // compression never rewrites the root itself
   `DSU_ASSERT_SAME(a_comp_not_root, clock, reset, state_ff == dsu_pkg::ST_COMP_CHK && mem_ctl.wr_en, waddr != root_ff)
   // a link only ever joins two distinct roots
   `DSU_ASSERT_SAME(a_link_distinct, clock, reset, state_ff == dsu_pkg::ST_LINK, ra_ff != root_ff)
   // the clearing sweep writes identity
   `DSU_ASSERT_SAME(a_clear_identity, clock, reset, state_ff == dsu_pkg::ST_CLEAR, mem_ctl.wr_en && wdata == waddr)

endmodule

// ===== design/disjoint_set_union_find_core.sv =====
// Channel   | Direction | Ports                                          | Handshake
// ----------+-----------+------------------------------------------------+--------------------
// request   | in        | req_kind, req_first_element, req_second_element | req_valid/req_ready
// response  | out       | rsp_root, rsp_merged                            | rsp_valid/rsp_ready
//
// Find: one table read per node on the path from the element to its root, then a second
// pass that reads the path again and points each node on it at the root.
// Unite: a find of each element back to back, plus a link write of the first root to the
// second when the roots differ. Clear: sweeps the table back to identity.
// After reset the table is swept to identity with req_ready low.
// The result sits in an output register; the next request is taken while it waits,
// and a finished item holds the sequencer only if that register is still full.

`include "disjoint_set_union_find_core_defines.svh"

module disjoint_set_union_find_core #(
   parameter int ELEMENTS = dsu_pkg::DSU_ELEMENTS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [dsu_pkg::KIND_W-1:0]    req_kind,
   input  logic [dsu_pkg::ELEM_W-1:0]    req_first_element,
   input  logic [dsu_pkg::ELEM_W-1:0]    req_second_element,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [dsu_pkg::ROOT_W-1:0]    rsp_root,
   output logic                          rsp_merged
);

   localparam int IDX_W = $clog2(ELEMENTS);
   localparam logic [dsu_pkg::CMP_W-1:0] ELEM_COUNT = dsu_pkg::CMP_W'(ELEMENTS);
   localparam logic [dsu_pkg::CMP_W-1:0] ELEM_LAST  = dsu_pkg::CMP_W'(ELEMENTS - 1);

   logic                      start;
   logic                      seq_ready;
   logic                      out_load;
   logic                      out_free;
   logic [IDX_W-1:0]          elem_a;
   logic [IDX_W-1:0]          elem_b;
   logic [IDX_W-1:0]          res_root;
   logic                      res_merged;
   logic [dsu_pkg::CMP_W-1:0] a_wide;
   logic [dsu_pkg::CMP_W-1:0] b_wide;
   logic [dsu_pkg::CMP_W-1:0] a_clamped;
   logic [dsu_pkg::CMP_W-1:0] b_clamped;
   logic [dsu_pkg::CMP_W-1:0] root_wide;

   dsu_pkg::dsu_mem_ctl_type mem_ctl;
   logic [IDX_W-1:0]         raddr;
   logic [IDX_W-1:0]         waddr;
   logic [IDX_W-1:0]         wdata;
   logic [IDX_W-1:0]         rdata;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [dsu_pkg::ROOT_W-1:0] rsp_root_ff, rsp_root_in;
   logic                       rsp_merged_ff, rsp_merged_in;

   // clamp elements past the end of the table to the last entry
   assign a_wide    = dsu_pkg::CMP_W'(req_first_element);
   assign b_wide    = dsu_pkg::CMP_W'(req_second_element);
   assign a_clamped = (a_wide >= ELEM_COUNT) ? ELEM_LAST : a_wide;
   assign b_clamped = (b_wide >= ELEM_COUNT) ? ELEM_LAST : b_wide;
   assign elem_a    = a_clamped[IDX_W-1:0];
   assign elem_b    = b_clamped[IDX_W-1:0];

   assign req_ready = seq_ready;
   assign start     = req_valid && seq_ready;

   // output slot can take a result when empty or being drained this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;

   dsu_seq #(
      .ELEMENTS (ELEMENTS)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .kind       (req_kind),
      .elem_a     (elem_a),
      .elem_b     (elem_b),
      .out_free   (out_free),
      .ready      (seq_ready),
      .out_load   (out_load),
      .res_root   (res_root),
      .res_merged (res_merged),
      .mem_ctl    (mem_ctl),
      .raddr      (raddr),
      .waddr      (waddr),
      .wdata      (wdata),
      .rdata      (rdata)
   );

   dsu_ram #(
      .ELEMENTS (ELEMENTS)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .raddr   (raddr),
      .waddr   (waddr),
      .wdata   (wdata),
      .rdata   (rdata)
   );

   // keep only the low root bits on wide tables
   assign root_wide = dsu_pkg::CMP_W'(res_root);

   // output register: load a finished result, drop valid once the transfer completes
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_root_in   = rsp_root_ff;
      rsp_merged_in = rsp_merged_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_root_in   = root_wide[dsu_pkg::ROOT_W-1:0];
         rsp_merged_in = res_merged;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_root_ff   <= rsp_root_in;
      rsp_merged_ff <= rsp_merged_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_root   = rsp_root_ff;
   assign rsp_merged = rsp_merged_ff;

   // a request transfer leaves the engine busy in the cycle after it
   `DSU_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

endmodule
